/* rtl/core/teq_pkg.sv */
// Shared types and constants of the timed event queue.
`timescale 1ns / 1ps
`default_nettype none
package teq_pkg;

    // Action codes carried by an event.
    localparam logic [1:0] ACT_MOUTH = 2'd0;
    localparam logic [1:0] ACT_GAZE  = 2'd1;
    localparam logic [1:0] ACT_BLINK = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // A tick releases at most this many events.
    localparam int MAX_RUN = 16;
    localparam int RUN_W   = $clog2(MAX_RUN);

    // One stored event.
    typedef struct packed {
        logic [31:0]        due;
        logic [1:0]         action;
        logic [3:0]         viseme;
        logic signed [15:0] look_x;
        logic signed [15:0] look_y;
        logic [15:0]        blink;
    } entry_t;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCHED,
        ST_TICK
    } state_t;

endpackage
`default_nettype wire

/* rtl/core/teq_cell.sv */
// One cell of the sorted event chain: holds one entry and its valid bit.
`timescale 1ns / 1ps
`default_nettype none
module teq_cell
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire teq_pkg::cell_ctrl_t ctrl,
    input  wire teq_pkg::entry_t     new_entry,
    input  wire teq_pkg::entry_t     left_entry,
    input  wire logic                left_valid,
    input  wire logic                left_gt,
    input  wire teq_pkg::entry_t     right_entry,
    input  wire logic                right_valid,
    output teq_pkg::entry_t          entry,
    output logic                     valid,
    output logic                     gt
);

    teq_pkg::entry_t entry_reg;
    teq_pkg::entry_t entry_next;
    logic            valid_reg;
    logic            valid_next;

    // This cell holds an event that is due strictly later than the new one.
    assign gt = valid_reg && (entry_reg.due > new_entry.due);

    // Insert shifts later entries one place right; pop shifts all one place left.
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            if (left_gt)
            begin
                entry_next = left_entry;
                valid_next = 1'b1;
            end
            else if (left_valid && (gt || !valid_reg))
            begin
                entry_next = new_entry;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    // Entry payload needs no reset; the valid bit does.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule
`default_nettype wire

/* rtl/core/timed_event_queue.sv */
// Top level of the timed event queue: item capture, sequencer and cell chain.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   An item is taken at a rising edge with start high and busy low. mode 0
//   schedules an event due at now_ms + delay_ms (modulo 2^32); mode 1 is a
//   tick that releases the stored events due at or before now_ms, at most 16.
//   Results appear on the event_* ports for one cycle each, marked by strobe.
//   For a schedule item the insert happens at once across the whole cell
//   chain, and its single status result (dropped set when the queue was
//   full) shows on the cycle after.
//   For a tick releasing n events (n at most 16), the head cell is popped
//   once per cycle, and results follow back to back, with last_of_run on
//   the final one. A tick with nothing due gives no result and returns to
//   idle.
//   busy is high while an item is in work; results may still be showing
//   in the first cycle busy is low. The receiver cannot stall results.
//   Reset empties the queue at once by clearing every cell's valid bit.
module timed_event_queue #(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               mode,
    input  wire logic [31:0]        now_ms,
    input  wire logic [31:0]        delay_ms,
    input  wire logic [1:0]         action_code,
    input  wire logic [3:0]         viseme,
    input  wire logic signed [15:0] look_x,
    input  wire logic signed [15:0] look_y,
    input  wire logic [15:0]        blink_len_ms,
    output logic                    strobe,
    output logic [1:0]              event_action,
    output logic [3:0]              event_viseme,
    output logic signed [15:0]      event_look_x,
    output logic signed [15:0]      event_look_y,
    output logic [15:0]             event_blink_ms,
    output logic                    dropped,
    output logic                    last_of_run
);

    teq_pkg::state_t             state_reg;
    teq_pkg::state_t             state_next;
    teq_pkg::entry_t             new_entry_reg;
    teq_pkg::entry_t             new_entry_next;
    logic [31:0]                 now_reg;
    logic [teq_pkg::RUN_W-1:0]   run_cnt_reg;
    logic [teq_pkg::RUN_W-1:0]   run_cnt_next;
    logic                        strobe_reg;
    logic                        strobe_next;
    teq_pkg::entry_t             res_reg;
    teq_pkg::entry_t             res_next;
    logic                        dropped_reg;
    logic                        dropped_next;
    logic                        last_reg;
    logic                        last_next;
    teq_pkg::cell_ctrl_t         ctrl;
    teq_pkg::entry_t             cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]      cell_valid;
    logic [QUEUE_DEPTH-1:0]      cell_gt;
    logic                        accept;
    logic                        head_due;
    logic                        second_due;
    logic                        run_end;

    assign accept = start && (state_reg == teq_pkg::ST_IDLE);
    assign busy   = (state_reg != teq_pkg::ST_IDLE);

    // Build the event to insert; fields foreign to the action are zeroed.
    always_comb
    begin
        new_entry_next        = '0;
        new_entry_next.due    = now_ms + delay_ms;
        new_entry_next.action = action_code;
        case (action_code)
            teq_pkg::ACT_MOUTH: new_entry_next.viseme = viseme;
            teq_pkg::ACT_GAZE:
            begin
                new_entry_next.look_x = look_x;
                new_entry_next.look_y = look_y;
            end
            teq_pkg::ACT_BLINK: new_entry_next.blink = blink_len_ms;
            default:            new_entry_next.viseme = 4'd0;
        endcase
    end

    // Captured item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_entry_reg <= new_entry_next;
            now_reg       <= now_ms;
        end
    end

    // Chain of cells, head at index 0.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        teq_pkg::entry_t left_e;
        teq_pkg::entry_t right_e;
        logic            left_v;
        logic            left_g;
        logic            right_v;

        if (i == 0)
        begin : g_head
            assign left_e = new_entry_reg;
            assign left_v = 1'b1;
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_v = cell_valid[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_e = cell_entry[i];
            assign right_v = 1'b0;
        end
        else
        begin : g_body
            assign right_e = cell_entry[i+1];
            assign right_v = cell_valid[i+1];
        end

        teq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_entry   (new_entry_reg),
            .left_entry  (left_e),
            .left_valid  (left_v),
            .left_gt     (left_g),
            .right_entry (right_e),
            .right_valid (right_v),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i])
        );
    end

    // Due checks on the head and the entry behind it.
    assign head_due   = cell_valid[0] && (cell_entry[0].due <= now_reg);
    assign second_due = cell_valid[1] && (cell_entry[1].due <= now_reg);
    assign run_end    = !second_due ||
                        (run_cnt_reg == teq_pkg::RUN_W'(teq_pkg::MAX_RUN - 1));

    // State register and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= teq_pkg::ST_IDLE;
            strobe_reg  <= 1'b0;
            run_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            strobe_reg  <= strobe_next;
            run_cnt_reg <= run_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        dropped_reg <= dropped_next;
        last_reg    <= last_next;
    end

    // Sequencer: next state, cell commands and result values.
    always_comb
    begin
        state_next   = state_reg;
        run_cnt_next = run_cnt_reg;
        strobe_next  = 1'b0;
        res_next     = res_reg;
        dropped_next = dropped_reg;
        last_next    = last_reg;
        ctrl         = '0;
        case (state_reg)
            teq_pkg::ST_IDLE:
            begin
                run_cnt_next = '0;
                if (accept)
                begin
                    state_next = mode ? teq_pkg::ST_TICK : teq_pkg::ST_SCHED;
                end
            end
            teq_pkg::ST_SCHED:
            begin
                ctrl.insert     = !cell_valid[QUEUE_DEPTH-1];
                strobe_next     = 1'b1;
                res_next        = '0;
                res_next.action = teq_pkg::ACT_NONE;
                dropped_next    = cell_valid[QUEUE_DEPTH-1];
                last_next       = 1'b1;
                state_next      = teq_pkg::ST_IDLE;
            end
            teq_pkg::ST_TICK:
            begin
                if (head_due)
                begin
                    ctrl.pop     = 1'b1;
                    strobe_next  = 1'b1;
                    res_next     = cell_entry[0];
                    dropped_next = 1'b0;
                    last_next    = run_end;
                    run_cnt_next = run_cnt_reg + 1'b1;
                    if (run_end)
                    begin
                        state_next = teq_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = teq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = teq_pkg::ST_IDLE;
            end
        endcase
    end

    assign strobe         = strobe_reg;
    assign event_action   = res_reg.action;
    assign event_viseme   = res_reg.viseme;
    assign event_look_x   = res_reg.look_x;
    assign event_look_y   = res_reg.look_y;
    assign event_blink_ms = res_reg.blink;
    assign dropped        = dropped_reg;
    assign last_of_run    = last_reg;

endmodule
`default_nettype wire

/* rtl/core/teq_checker.sv */
// Port-level checks of the timed event queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module teq_checker
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic               mode,
    input  wire logic               strobe,
    input  wire logic [1:0]         event_action,
    input  wire logic               dropped,
    input  wire logic               last_of_run
);

    // A release run has no gaps until its last item.
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_of_run |=> strobe)
        else $error("release run broken before its last item");

    // A schedule item gives its status after acceptance, marked last of run with action none.
    a_sched_status: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !mode |=> ##1
            (strobe && last_of_run && event_action == teq_pkg::ACT_NONE))
        else $error("schedule status missing or malformed");

    // A drop report is a lone status item.
    a_drop_status: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && dropped |-> last_of_run && event_action == teq_pkg::ACT_NONE)
        else $error("drop reported on a released event");

    // Results come only from an item in work.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result without an item in work");

endmodule

bind timed_event_queue teq_checker u_teq_checker (.*);
`default_nettype wire

/* tb/sv/timed_event_queue_tb.sv */
// Self-checking testbench of the timed event queue: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps
module timed_event_queue_tb;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 136;
    localparam int QUIET_TAIL   = 30;

    // How the result of a directed row is checked.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_STATUS,
        CHK_QUIET
    } row_check_t;

    // One input item as the testbench drives it.
    typedef struct {
        logic               mode;
        logic [31:0]        now;
        logic [31:0]        delay;
        logic [1:0]         act;
        logic [3:0]         vis;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic [15:0]        blink;
        row_check_t         chk;
        logic               drop;
    } stim_t;

    // One result item as seen on the event ports.
    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         viseme;
        logic signed [15:0] look_x;
        logic signed [15:0] look_y;
        logic [15:0]        blink;
        logic               dropped;
        logic               last_run;
    } event_rec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               mode = 1'b0;
    logic [31:0]        now_ms = '0;
    logic [31:0]        delay_ms = '0;
    logic [1:0]         action_code = teq_pkg::ACT_NONE;
    logic [3:0]         viseme = '0;
    logic signed [15:0] look_x = '0;
    logic signed [15:0] look_y = '0;
    logic [15:0]        blink_len_ms = '0;
    logic               busy;
    logic               strobe;
    logic [1:0]         event_action;
    logic [3:0]         event_viseme;
    logic signed [15:0] event_look_x;
    logic signed [15:0] event_look_y;
    logic [15:0]        event_blink_ms;
    logic               dropped;
    logic               last_of_run;

    row_check_t cur_chk = CHK_MODEL;
    logic       cur_drop = 1'b0;
    bit         gaps_enabled = 1'b1;
    int         random_sent = 0;
    int         mismatch_count = 0;
    logic [31:0] sim_clock_ms;

    teq_pkg::entry_t stored_events[$];
    event_rec_t      released_now[$];
    event_rec_t      pending_events[$];
    stim_t           directed_rows[$];

    always #5 clk = ~clk;

    timed_event_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .now_ms(now_ms),
        .delay_ms(delay_ms),
        .action_code(action_code),
        .viseme(viseme),
        .look_x(look_x),
        .look_y(look_y),
        .blink_len_ms(blink_len_ms),
        .strobe(strobe),
        .event_action(event_action),
        .event_viseme(event_viseme),
        .event_look_x(event_look_x),
        .event_look_y(event_look_y),
        .event_blink_ms(event_blink_ms),
        .dropped(dropped),
        .last_of_run(last_of_run)
    );

    // Sorted shadow of the queue: a schedule inserts after every entry due no later,
    // a tick pops due entries from the head, at most one run's worth.
    function automatic void advance_event_queue(input logic md, input logic [31:0] now,
                                                input logic [31:0] delay, input logic [1:0] act,
                                                input logic [3:0] vis,
                                                input logic signed [15:0] lx,
                                                input logic signed [15:0] ly,
                                                input logic [15:0] blink);
        teq_pkg::entry_t ent;
        event_rec_t      rec;
        int              pos;
        int              n;
        released_now.delete();
        rec = '0;
        if (md == 1'b0)
        begin
            rec.action = teq_pkg::ACT_NONE;
            rec.last_run = 1'b1;
            if (stored_events.size() >= QUEUE_DEPTH)
            begin
                rec.dropped = 1'b1;
            end
            else
            begin
                ent.due    = now + delay;
                ent.action = act;
                ent.viseme = (act == teq_pkg::ACT_MOUTH) ? vis : 4'd0;
                ent.look_x = (act == teq_pkg::ACT_GAZE) ? lx : 16'sd0;
                ent.look_y = (act == teq_pkg::ACT_GAZE) ? ly : 16'sd0;
                ent.blink  = (act == teq_pkg::ACT_BLINK) ? blink : 16'd0;
                pos = stored_events.size();
                while (pos > 0 && stored_events[pos - 1].due > ent.due)
                    pos--;
                stored_events.insert(pos, ent);
            end
            released_now.push_back(rec);
        end
        else
        begin
            n = 0;
            while (stored_events.size() > 0 && n < teq_pkg::MAX_RUN &&
                   stored_events[0].due <= now)
            begin
                ent = stored_events.pop_front();
                rec.action   = ent.action;
                rec.viseme   = ent.viseme;
                rec.look_x   = ent.look_x;
                rec.look_y   = ent.look_y;
                rec.blink    = ent.blink;
                rec.dropped  = 1'b0;
                rec.last_run = 1'b0;
                released_now.push_back(rec);
                n++;
            end
            if (n > 0)
                released_now[n - 1].last_run = 1'b1;
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Scoreboard: check the strobed result against the oldest expectation, then
    // record the expectations of an item taken at this edge.
    always @(posedge clk)
    begin : scoreboard
        event_rec_t want;
        event_rec_t status;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (pending_events.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got action %0d last %0b",
                             $time, event_action, last_of_run);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("event_action", 32'(want.action), 32'(event_action));
                    check_field("event_viseme", 32'(want.viseme), 32'(event_viseme));
                    check_field("event_look_x", 32'(want.look_x), 32'(event_look_x));
                    check_field("event_look_y", 32'(want.look_y), 32'(event_look_y));
                    check_field("event_blink_ms", 32'(want.blink), 32'(event_blink_ms));
                    check_field("dropped", 32'(want.dropped), 32'(dropped));
                    check_field("last_of_run", 32'(want.last_run), 32'(last_of_run));
                end
            end
            if (start && !busy)
            begin
                advance_event_queue(mode, now_ms, delay_ms, action_code, viseme,
                                    look_x, look_y, blink_len_ms);
                case (cur_chk)
                    CHK_STATUS:
                    begin
                        status = '0;
                        status.action = teq_pkg::ACT_NONE;
                        status.dropped = cur_drop;
                        status.last_run = 1'b1;
                        pending_events.push_back(status);
                    end
                    CHK_QUIET:
                    begin
                    end
                    default:
                    begin
                        foreach (released_now[i])
                            pending_events.push_back(released_now[i]);
                    end
                endcase
            end
        end
    end

    function automatic void add_row(input logic md, input logic [31:0] now,
                                    input logic [31:0] delay, input logic [1:0] act,
                                    input logic [3:0] vis, input logic signed [15:0] lx,
                                    input logic signed [15:0] ly, input logic [15:0] blink,
                                    input row_check_t chk, input logic drop);
        stim_t s;
        s.mode  = md;
        s.now   = now;
        s.delay = delay;
        s.act   = act;
        s.vis   = vis;
        s.lx    = lx;
        s.ly    = ly;
        s.blink = blink;
        s.chk   = chk;
        s.drop  = drop;
        directed_rows.push_back(s);
    endfunction

    function automatic stim_t sched_item(input logic [31:0] now, input logic [31:0] delay);
        stim_t s;
        s.mode  = 1'b0;
        s.now   = now;
        s.delay = delay;
        s.act   = 2'($urandom_range(0, 3));
        s.vis   = 4'($urandom);
        s.lx    = 16'($urandom);
        s.ly    = 16'($urandom);
        s.blink = 16'($urandom);
        s.chk   = CHK_MODEL;
        s.drop  = 1'b0;
        return s;
    endfunction

    function automatic stim_t tick_item(input logic [31:0] now);
        stim_t s;
        s = sched_item(now, 32'($urandom));
        s.mode = 1'b1;
        return s;
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_item(input stim_t s);
        mode         <= s.mode;
        now_ms       <= s.now;
        delay_ms     <= s.delay;
        action_code  <= s.act;
        viseme       <= s.vis;
        look_x       <= s.lx;
        look_y       <= s.ly;
        blink_len_ms <= s.blink;
        cur_chk      <= s.chk;
        cur_drop     <= s.drop;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Optional burst of idle cycles after an accepted item.
    task automatic pause_maybe();
        if (gaps_enabled && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic emit(input stim_t s);
        send_item(s);
        pause_maybe();
        random_sent++;
    endtask

    initial
    begin : stimulus
        int n;
        int drain_wait;
        logic [31:0] dly;

        // Empty queue, fill with edge payloads and wrapped due times, overflow, then drain.
        add_row(1'b1, 32'd0, 32'd0, teq_pkg::ACT_NONE, 4'd0, 16'sd0, 16'sd0, 16'd0,
                CHK_QUIET, 1'b0);
        add_row(1'b0, 32'd100, 32'd0, teq_pkg::ACT_MOUTH, 4'd15, -16'sd1, 16'sd5, 16'd7,
                CHK_STATUS, 1'b0);
        add_row(1'b0, 32'd100, 32'd0, teq_pkg::ACT_GAZE, 4'd3, -16'sd32768, 16'sd32767, 16'd9,
                CHK_STATUS, 1'b0);
        add_row(1'b0, 32'd100, 32'd0, teq_pkg::ACT_BLINK, 4'd0, 16'sd0, 16'sd0, 16'hFFFF,
                CHK_STATUS, 1'b0);
        add_row(1'b0, 32'd100, 32'd0, teq_pkg::ACT_NONE, 4'd15, -16'sd1, -16'sd1, 16'hFFFF,
                CHK_STATUS, 1'b0);
        add_row(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, teq_pkg::ACT_GAZE, 4'd0, 16'sd32767,
                -16'sd32768, 16'd0, CHK_STATUS, 1'b0);
        add_row(1'b0, 32'd200, 32'hFFFF_FFFF, teq_pkg::ACT_MOUTH, 4'd0, 16'sd0, 16'sd0, 16'd0,
                CHK_STATUS, 1'b0);
        add_row(1'b0, 32'd0, 32'd0, teq_pkg::ACT_BLINK, 4'd0, 16'sd0, 16'sd0, 16'd0,
                CHK_STATUS, 1'b0);
        add_row(1'b0, 32'd0, 32'd99, teq_pkg::ACT_MOUTH, 4'd9, 16'sd0, 16'sd0, 16'd0,
                CHK_STATUS, 1'b0);
        add_row(1'b0, 32'd30, 32'd69, teq_pkg::ACT_GAZE, 4'd0, 16'sd16384, -16'sd16384, 16'd0,
                CHK_STATUS, 1'b0);
        add_row(1'b0, 32'd1000, 32'd5000, teq_pkg::ACT_BLINK, 4'd0, 16'sd0, 16'sd0, 16'd300,
                CHK_STATUS, 1'b0);
        add_row(1'b0, 32'd40, 32'd10, teq_pkg::ACT_MOUTH, 4'd1, 16'sd0, 16'sd0, 16'd0,
                CHK_STATUS, 1'b0);
        add_row(1'b0, 32'd7, 32'd7, teq_pkg::ACT_NONE, 4'd6, 16'sd3, 16'sd4, 16'd5,
                CHK_STATUS, 1'b0);
        add_row(1'b0, 32'h8000_0000, 32'd0, teq_pkg::ACT_BLINK, 4'd0, 16'sd0, 16'sd0, 16'd1,
                CHK_STATUS, 1'b0);
        add_row(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, teq_pkg::ACT_MOUTH, 4'd10, 16'sh5555,
                16'shAAAA, 16'h5555, CHK_STATUS, 1'b0);
        add_row(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, teq_pkg::ACT_GAZE, 4'd5, 16'sh5555,
                16'shAAAA, 16'hAAAA, CHK_STATUS, 1'b0);
        add_row(1'b0, 32'd100, 32'd0, teq_pkg::ACT_MOUTH, 4'd5, 16'sd0, 16'sd0, 16'd0,
                CHK_STATUS, 1'b0);
        add_row(1'b0, 32'd0, 32'd0, teq_pkg::ACT_GAZE, 4'd2, 16'sd1, 16'sd1, 16'd1,
                CHK_STATUS, 1'b1);
        add_row(1'b1, 32'd99, 32'd0, teq_pkg::ACT_NONE, 4'd0, 16'sd0, 16'sd0, 16'd0,
                CHK_MODEL, 1'b0);
        add_row(1'b1, 32'd100, 32'd0, teq_pkg::ACT_NONE, 4'd0, 16'sd0, 16'sd0, 16'd0,
                CHK_MODEL, 1'b0);
        add_row(1'b1, 32'hFFFF_FFFE, 32'd0, teq_pkg::ACT_NONE, 4'd0, 16'sd0, 16'sd0, 16'd0,
                CHK_MODEL, 1'b0);
        add_row(1'b1, 32'hFFFF_FFFF, 32'd0, teq_pkg::ACT_NONE, 4'd0, 16'sd0, 16'sd0, 16'd0,
                CHK_MODEL, 1'b0);
        add_row(1'b1, 32'hFFFF_FFFF, 32'd0, teq_pkg::ACT_NONE, 4'd0, 16'sd0, 16'sd0, 16'd0,
                CHK_QUIET, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i]);
            pause_maybe();
        end

        // Random traffic: fill bursts that overflow and release full runs, and mixed
        // schedule and tick traffic around a moving time base with some wild values.
        sim_clock_ms = $urandom_range(0, 1000);
        while (random_sent < RANDOM_ITEMS)
        begin
            gaps_enabled = (random_sent < RANDOM_ITEMS - QUIET_TAIL) &&
                           ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(12, 20);
                repeat (n) emit(sched_item(sim_clock_ms, $urandom_range(0, 60)));
                sim_clock_ms = sim_clock_ms + 100;
                emit(tick_item(sim_clock_ms));
            end
            else
            begin
                repeat (8)
                begin
                    if ($urandom_range(0, 9) < 6)
                    begin
                        dly = ($urandom_range(0, 9) == 0) ? 32'($urandom) : $urandom_range(0, 300);
                        emit(sched_item(($urandom_range(0, 11) == 0) ? 32'($urandom)
                                                                    : sim_clock_ms, dly));
                    end
                    else
                    begin
                        sim_clock_ms = sim_clock_ms + $urandom_range(0, 150);
                        emit(tick_item(($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF
                                                                  : sim_clock_ms));
                    end
                end
            end
        end
        start <= 1'b0;

        // Let the last item finish and its results come out.
        drain_wait = 0;
        while (pending_events.size() != 0 && drain_wait < 2000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (20) @(posedge clk);

        if (pending_events.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived, first expected action %0d",
                     $time, pending_events.size(), pending_events[0].action);
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("timed_event_queue_tb: PASS");
        else
            $display("timed_event_queue_tb: FAIL");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("timed_event_queue_tb: FAIL");
        $finish;
    end

endmodule
